// ===== sv/deq_pkg.sv =====
// Shared sizes, operation and status codes, and the bundles passed between the
// queue control and the top level of the double-ended entry queue.
// No dependencies.
`default_nettype none

package deq_pkg;

	localparam int DEPTH       = 16;
	localparam int WIDTH       = 32;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int OP_W        = 3;
	localparam int ST_W        = 2;
	localparam int IN_TDATA_W  = ((OP_W + WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((WIDTH + ST_W + CNT_W + 7) / 8) * 8;

	typedef logic [OP_W-1:0] op_t;
	typedef logic [ST_W-1:0] status_t;

	localparam op_t OP_PUSH_REAR  = 3'd0;
	localparam op_t OP_POP_FRONT  = 3'd1;
	localparam op_t OP_PUSH_FRONT = 3'd2;
	localparam op_t OP_READ_REAR  = 3'd3;
	localparam op_t OP_CLEAR      = 3'd4;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	// Store access issued for one transfer
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [WIDTH-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// Result bookkeeping that waits for the store read
	typedef struct packed {
		status_t          status;
		logic [CNT_W-1:0] count;
		logic             rd;
	} op_res_t;

endpackage

`default_nettype wire

// ===== sv/deq_ram.sv =====
// Generic single-write, single-read synchronous memory with registered read data.
// No dependencies.
`default_nettype none

module deq_ram #(
	parameter int AW = 4,
	parameter int DW = 32
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== sv/deq_ctrl.sv =====
// Queue control: head, tail and occupancy registers, operation decode and the
// store access for each transfer. Depends on deq_pkg.
`default_nettype none

module deq_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           accept,
	input  wire deq_pkg::op_t                   op,
	input  wire logic [deq_pkg::WIDTH-1:0]      data,
	output deq_pkg::mem_req_t                   mem_req,
	output deq_pkg::op_res_t                    res
);

	localparam logic [deq_pkg::ADDR_W-1:0] LAST_SLOT = deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1);
	localparam logic [deq_pkg::CNT_W-1:0]  FULL_CNT  = deq_pkg::CNT_W'(deq_pkg::DEPTH);

	logic [deq_pkg::ADDR_W-1:0] head_q, tail_q, head_d, tail_d;
	logic [deq_pkg::CNT_W-1:0]  count_q, count_d;
	logic                       empty, full;
	deq_pkg::mem_req_t          req;

	function automatic logic [deq_pkg::ADDR_W-1:0] next_slot(input logic [deq_pkg::ADDR_W-1:0] i);
		next_slot = (i == LAST_SLOT) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [deq_pkg::ADDR_W-1:0] prev_slot(input logic [deq_pkg::ADDR_W-1:0] i);
		prev_slot = (i == '0) ? LAST_SLOT : i - 1'b1;
	endfunction

	assign empty = (count_q == '0);
	assign full  = (count_q == FULL_CNT);

	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		count_d    = count_q;
		req        = '0;
		res.status = deq_pkg::ST_OK;
		res.rd     = 1'b0;
		case (op)
			deq_pkg::OP_PUSH_REAR: begin
				if (full) begin
					res.status = deq_pkg::ST_FULL;
				end else begin
					req.we    = 1'b1;
					req.waddr = tail_q;
					req.wdata = data;
					tail_d    = next_slot(tail_q);
					count_d   = count_q + 1'b1;
				end
			end
			deq_pkg::OP_POP_FRONT: begin
				if (empty) begin
					res.status = deq_pkg::ST_EMPTY;
				end else begin
					req.re    = 1'b1;
					req.raddr = head_q;
					res.rd    = 1'b1;
					head_d    = next_slot(head_q);
					count_d   = count_q - 1'b1;
				end
			end
			deq_pkg::OP_PUSH_FRONT: begin
				if (empty) begin
					res.status = deq_pkg::ST_EMPTY;
				end else if (full) begin
					res.status = deq_pkg::ST_FULL;
				end else begin
					head_d    = prev_slot(head_q);
					req.we    = 1'b1;
					req.waddr = prev_slot(head_q);
					req.wdata = data;
					count_d   = count_q + 1'b1;
				end
			end
			deq_pkg::OP_READ_REAR: begin
				if (empty) begin
					res.status = deq_pkg::ST_EMPTY;
				end else begin
					req.re    = 1'b1;
					req.raddr = prev_slot(tail_q);
					res.rd    = 1'b1;
				end
			end
			deq_pkg::OP_CLEAR: begin
				head_d  = '0;
				tail_d  = '0;
				count_d = '0;
			end
			default: begin
			end
		endcase
		res.count = count_d;
	end

	always_comb begin
		mem_req    = req;
		mem_req.we = req.we & accept;
		mem_req.re = req.re & accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT) else $error("occupancy beyond depth");

	a_empty_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == tail_q)) else $error("empty queue with split pointers");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> !full) else $error("store write into full queue");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == deq_pkg::OP_CLEAR) |=> (count_q == '0 && head_q == '0 && tail_q == '0))
		else $error("clear left entries");

endmodule

`default_nettype wire

// ===== sv/double_ended_entry_queue.sv =====
// Double-ended entry queue: 16 words of 32 bits in a ring held in a synchronous
// memory. One operation per transfer (push rear, pop front, push front, read rear,
// clear) gives one result of data, status and count. An operation is taken every
// cycle while results drain. A transfer updates the pointers and loads the read stage
// (the registered store read and its bookkeeping); the read stage then loads the
// result register when that is free or draining. A stalled result register holds the
// pipeline. Depends on deq_pkg, deq_ctrl and deq_ram.
`default_nettype none

module double_ended_entry_queue (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// opcode[2:0], data_in[34:3], zero fill above
	input  wire logic [deq_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// data_out[31:0], status[33:32], count[38:34], zero fill above
	output logic      [deq_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	localparam int OUT_USED = deq_pkg::WIDTH + deq_pkg::ST_W + deq_pkg::CNT_W;

	logic                        accept, advance;
	deq_pkg::op_t                op;
	logic [deq_pkg::WIDTH-1:0]   data_in;
	deq_pkg::mem_req_t           mem_req;
	deq_pkg::op_res_t            res, res_s1;
	logic                        valid_s1;
	logic [deq_pkg::WIDTH-1:0]   rd_data;
	logic                        m_valid_q;
	logic [deq_pkg::WIDTH-1:0]   data_out_q;
	deq_pkg::status_t            status_q;
	logic [deq_pkg::CNT_W-1:0]   count_q;

	assign op      = s_tdata[deq_pkg::OP_W-1:0];
	assign data_in = s_tdata[deq_pkg::OP_W +: deq_pkg::WIDTH];

	// Advance the read stage only when the result register is free or draining
	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	deq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.op      (op),
		.data    (data_in),
		.mem_req (mem_req),
		.res     (res)
	);

	deq_ram #(
		.AW (deq_pkg::ADDR_W),
		.DW (deq_pkg::WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_out_q <= res_s1.rd ? rd_data : '0;
			status_q   <= res_s1.status;
			count_q    <= res_s1.count;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(deq_pkg::OUT_TDATA_W - OUT_USED){1'b0}}, count_q, status_q, data_out_q};

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && m_valid_q && !m_tready) |=> (valid_s1 && $stable(res_s1)))
		else $error("read stage lost under stall");

	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res_s1.rd) |-> (res_s1.status == deq_pkg::ST_OK))
		else $error("store read with error status");

	a_no_accept_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> !accept) else $error("transfer taken into full stage");

endmodule

`default_nettype wire

// ===== tb/deq_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the double-ended entry queue: watches both stream channels,
// keeps its own copy of the ring and compares every result field by field.
// Depends on deq_pkg.

module deq_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	input  wire logic                           s_tready,
	// opcode[2:0], data_in[34:3], zero fill above
	input  wire logic [deq_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  wire logic                           m_tvalid,
	input  wire logic                           m_tready,
	// data_out[31:0], status[33:32], count[38:34], zero fill above
	input  wire logic [deq_pkg::OUT_TDATA_W-1:0] m_tdata,
	output int                                  mismatches,
	output int                                  outstanding
);
	import deq_pkg::*;

	typedef struct packed {
		logic [WIDTH-1:0] data;
		status_t          status;
		logic [CNT_W-1:0] count;
	} deq_result_t;

	// Shadow copy of the queue
	logic [WIDTH-1:0]  slots [DEPTH];
	logic [ADDR_W-1:0] head_slot;
	logic [ADDR_W-1:0] tail_slot;
	logic [CNT_W-1:0]  fill_level;

	deq_result_t awaited_results [$];

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	function automatic logic [ADDR_W-1:0] slot_after(input logic [ADDR_W-1:0] s);
		return (s == ADDR_W'(DEPTH - 1)) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [ADDR_W-1:0] slot_before(input logic [ADDR_W-1:0] s);
		return (s == '0) ? ADDR_W'(DEPTH - 1) : s - 1'b1;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// Apply one operation to the shadow queue and work out its result
	task automatic apply_op(input op_t op, input logic [WIDTH-1:0] word,
			output deq_result_t res);
		res = '0;
		res.status = ST_OK;
		case (op)
		OP_PUSH_REAR: begin
			if (fill_level == CNT_W'(DEPTH)) begin
				res.status = ST_FULL;
			end else begin
				slots[tail_slot] = word;
				tail_slot = slot_after(tail_slot);
				fill_level = fill_level + 1'b1;
			end
		end
		OP_POP_FRONT: begin
			if (fill_level == '0) begin
				res.status = ST_EMPTY;
			end else begin
				res.data = slots[head_slot];
				head_slot = slot_after(head_slot);
				fill_level = fill_level - 1'b1;
			end
		end
		OP_PUSH_FRONT: begin
			// refused on an empty queue as well as a full one
			if (fill_level == '0) begin
				res.status = ST_EMPTY;
			end else if (fill_level == CNT_W'(DEPTH)) begin
				res.status = ST_FULL;
			end else begin
				head_slot = slot_before(head_slot);
				slots[head_slot] = word;
				fill_level = fill_level + 1'b1;
			end
		end
		OP_READ_REAR: begin
			if (fill_level == '0)
				res.status = ST_EMPTY;
			else
				res.data = slots[slot_before(tail_slot)];
		end
		OP_CLEAR: begin
			head_slot  = '0;
			tail_slot  = '0;
			fill_level = '0;
		end
		default: begin
		end
		endcase
		res.count = fill_level;
	endtask

	always @(posedge clk or negedge arst_n) begin
		deq_result_t want;
		deq_result_t got;
		if (!arst_n) begin
			head_slot  = '0;
			tail_slot  = '0;
			fill_level = '0;
			awaited_results.delete();
			outstanding <= 0;
		end else begin
			// predict first so a same-edge result still finds its entry
			if (s_tvalid && s_tready) begin
				apply_op(s_tdata[OP_W-1:0], s_tdata[OP_W +: WIDTH], want);
				awaited_results.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got.data   = m_tdata[WIDTH-1:0];
				got.status = m_tdata[WIDTH +: ST_W];
				got.count  = m_tdata[WIDTH + ST_W +: CNT_W];
				if (awaited_results.size() == 0) begin
					flag_mismatch($sformatf("result %h with none awaited", m_tdata));
				end else begin
					want = awaited_results.pop_front();
					if (got.data !== want.data)
						flag_mismatch($sformatf("data_out %h, want %h",
							got.data, want.data));
					if (got.status !== want.status)
						flag_mismatch($sformatf("status %0d, want %0d",
							got.status, want.status));
					if (got.count !== want.count)
						flag_mismatch($sformatf("count %0d, want %0d",
							got.count, want.count));
				end
			end
			outstanding <= awaited_results.size();
		end
	end

endmodule

// ===== tb/tb_double_ended_entry_queue.sv =====
`timescale 1ns / 100ps
// Top of the queue testbench: clock, reset, operation stream and result stalls.
// Checking is left to deq_checker. Depends on deq_pkg, deq_checker and the queue.

module tb_double_ended_entry_queue;
	import deq_pkg::*;

	localparam int   CYCLE_LIMIT  = 200000;
	localparam int   DRAIN_CYCLES = 12;
	localparam int   PHASE_ITEMS  = 112;
	// opcodes with no operation behind them
	localparam op_t  OP_SPARE_A   = 3'd5;
	localparam op_t  OP_SPARE_B   = 3'd6;
	localparam op_t  OP_SPARE_C   = 3'd7;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [IN_TDATA_W-1:0]   s_tdata;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [OUT_TDATA_W-1:0]  m_tdata;

	int mismatches;
	int outstanding;
	int cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	always #2 clk = ~clk;

	double_ended_entry_queue DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	deq_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Hold the transfer until the queue takes it, with random idle cycles ahead
	task automatic send_op(input op_t op, input logic [WIDTH-1:0] word);
		logic [IN_TDATA_W-1:0] beat;
		beat = '0;
		beat[OP_W-1:0]    = op;
		beat[OP_W +: WIDTH] = word;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= beat;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	function automatic logic [WIDTH-1:0] pick_word();
		case ($urandom_range(15))
		0:       return '0;
		1:       return '1;
		default: return WIDTH'($urandom);
		endcase
	endfunction

	// Filling runs lean on pushes to reach a full queue, draining runs on pops
	function automatic op_t pick_op(input bit filling);
		int r;
		r = $urandom_range(99);
		if (filling) begin
			if (r < 45) return OP_PUSH_REAR;
			if (r < 70) return OP_PUSH_FRONT;
			if (r < 82) return OP_POP_FRONT;
			if (r < 92) return OP_READ_REAR;
		end else begin
			if (r < 50) return OP_POP_FRONT;
			if (r < 62) return OP_PUSH_REAR;
			if (r < 72) return OP_PUSH_FRONT;
			if (r < 88) return OP_READ_REAR;
		end
		case ($urandom_range(3))
		0:       return OP_CLEAR;
		1:       return OP_SPARE_A;
		2:       return OP_SPARE_B;
		default: return OP_SPARE_C;
		endcase
	endfunction

	initial begin
		bit filling;
		int run_left;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		filling  = 1'b1;
		run_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// empty-queue errors and a spare opcode
		send_op(OP_POP_FRONT, pick_word());
		send_op(OP_READ_REAR, pick_word());
		send_op(OP_PUSH_FRONT, '1);
		send_op(OP_SPARE_C, '1);
		// extreme words at both ends, then fill up and push past full
		send_op(OP_PUSH_REAR, '1);
		send_op(OP_PUSH_FRONT, '0);
		send_op(OP_READ_REAR, '0);
		for (int i = 0; i < DEPTH - 2; i++)
			send_op(OP_PUSH_REAR, WIDTH'($urandom));
		send_op(OP_PUSH_REAR, pick_word());
		send_op(OP_PUSH_FRONT, pick_word());
		send_op(OP_POP_FRONT, '0);
		send_op(OP_CLEAR, '0);
		// pop the only entry
		send_op(OP_PUSH_REAR, pick_word());
		send_op(OP_POP_FRONT, '0);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 45; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 45; end
			default: begin idle_pct = 35; stall_pct = 35; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (run_left == 0) begin
					filling  = !filling;
					run_left = $urandom_range(8, 40);
				end
				run_left--;
				send_op(pick_op(filling), pick_word());
			end
		end
		s_tvalid <= 1'b0;

		// let the count of the last transfer settle before watching it drain
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
